// ===== hdl/prefix_suffix_string_acceptor_top_assert.svh =====
// assertion macros for the checker file
`ifndef PREFIX_SUFFIX_STRING_ACCEPTOR_TOP_ASSERT_SVH
`define PREFIX_SUFFIX_STRING_ACCEPTOR_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSA_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSA_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/psa_pkg.sv =====
package psa_pkg;

    localparam int PREFIX_MAX_DEF = 8;
    localparam int SUFFIX_MAX_DEF = 8;
    localparam int SYM_W          = 8;
    localparam int LEN_W          = 4;
    localparam int CFG_W          = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int ALPHA_BANKS    = 4;
    localparam logic [LEN_W-1:0] LEN_LIMIT = 4'd8;

    localparam logic KIND_SYMBOL = 1'b0;
    localparam logic KIND_END    = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PREFIX_CHARS = 3'd0,
        CFG_PREFIX_LEN   = 3'd1,
        CFG_SUFFIX_CHARS = 3'd2,
        CFG_SUFFIX_LEN   = 3'd3,
        CFG_ALPHA_0      = 3'd4,
        CFG_ALPHA_1      = 3'd5,
        CFG_ALPHA_2      = 3'd6,
        CFG_ALPHA_3      = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CONSUMED        = 3'd0,
        ST_NOT_IN_ALPHA    = 3'd1,
        ST_PREFIX_MISMATCH = 3'd2,
        ST_IGNORED         = 3'd3,
        ST_ACCEPTED        = 3'd4,
        ST_REJECTED        = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_ALPHABET = 2'd1,
        ERR_PREFIX   = 2'd2
    } err_t;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] symbol;
        logic             in_alpha;
    } mid_item_t;

    typedef struct packed {
        status_t          status;
        logic [LEN_W-1:0] prefix_progress;
        logic [LEN_W-1:0] suffix_progress;
    } out_item_t;

endpackage

// ===== hdl/psa_queue.sv =====
module psa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    // two-entry queue: enough to keep one beat per cycle across registered flags while the reader keeps popping
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/psa_front.sv =====
module psa_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psa_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                push,
    input  logic                                kind,
    input  logic [psa_pkg::SYM_W-1:0]           symbol,
    input  logic                                q_full,
    output logic                                q_push,
    output psa_pkg::mid_item_t                  q_item
);

    // alphabet membership, 64 byte values per bank
    logic [psa_pkg::CFG_W-1:0] alpha_reg [psa_pkg::ALPHA_BANKS];
    logic [psa_pkg::CFG_W-1:0] bank;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < psa_pkg::ALPHA_BANKS; b++)
            begin
                alpha_reg[b] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (psa_pkg::cfg_idx_t'(cfg_index))
                psa_pkg::CFG_ALPHA_0: alpha_reg[0] <= cfg_data;
                psa_pkg::CFG_ALPHA_1: alpha_reg[1] <= cfg_data;
                psa_pkg::CFG_ALPHA_2: alpha_reg[2] <= cfg_data;
                psa_pkg::CFG_ALPHA_3: alpha_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign bank   = alpha_reg[symbol[7:6]];
    assign q_push = push && !q_full;

    always_comb
    begin
        q_item.kind     = kind;
        q_item.symbol   = symbol;
        q_item.in_alpha = bank[symbol[5:0]];
    end

endmodule

// ===== hdl/psa_back.sv =====
module psa_back #(
    parameter int PREFIX_MAX = psa_pkg::PREFIX_MAX_DEF,
    parameter int SUFFIX_MAX = psa_pkg::SUFFIX_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psa_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    input  psa_pkg::mid_item_t                  in_item,
    output logic                                in_pop,
    input  logic                                out_full,
    output logic                                out_push,
    output psa_pkg::out_item_t                  out_item
);

    localparam int WIN_IDX_W = (SUFFIX_MAX > 1) ? $clog2(SUFFIX_MAX) : 1;
    localparam logic [psa_pkg::LEN_W-1:0] PLEN_MAX = psa_pkg::LEN_W'(PREFIX_MAX);
    localparam logic [psa_pkg::LEN_W-1:0] SLEN_MAX = psa_pkg::LEN_W'(SUFFIX_MAX);

    logic [psa_pkg::CFG_W-1:0]    prefix_chars_reg;
    logic [psa_pkg::LEN_W-1:0]    prefix_len_reg;
    logic [psa_pkg::CFG_W-1:0]    suffix_chars_reg;
    logic [psa_pkg::LEN_W-1:0]    suffix_len_reg;

    logic [psa_pkg::LEN_W-1:0]    prefix_count_reg;
    logic [psa_pkg::LEN_W-1:0]    prefix_count_next;
    logic [psa_pkg::LEN_W-1:0]    after_count_reg;
    logic [psa_pkg::LEN_W-1:0]    after_count_next;
    psa_pkg::err_t                err_reg;
    psa_pkg::err_t                err_next;
    logic [psa_pkg::SYM_W-1:0]    win_reg  [SUFFIX_MAX];
    logic [psa_pkg::SYM_W-1:0]    win_next [SUFFIX_MAX];

    logic [psa_pkg::LEN_W-1:0]    plen;
    logic [psa_pkg::LEN_W-1:0]    slen;
    logic [psa_pkg::SYM_W-1:0]    prefix_byte;
    logic                         suffix_hit;
    logic                         end_ok;
    logic [psa_pkg::LEN_W-1:0]    after_inc;
    logic                         fire;
    psa_pkg::status_t             status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_chars_reg <= '0;
            prefix_len_reg   <= '0;
            suffix_chars_reg <= '0;
            suffix_len_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (psa_pkg::cfg_idx_t'(cfg_index))
                psa_pkg::CFG_PREFIX_CHARS: prefix_chars_reg <= cfg_data;
                psa_pkg::CFG_PREFIX_LEN:   prefix_len_reg   <= cfg_data[psa_pkg::LEN_W-1:0];
                psa_pkg::CFG_SUFFIX_CHARS: suffix_chars_reg <= cfg_data;
                psa_pkg::CFG_SUFFIX_LEN:   suffix_len_reg   <= cfg_data[psa_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // lengths above the build limit count as the limit
    assign plen = (prefix_len_reg > PLEN_MAX) ? PLEN_MAX : prefix_len_reg;
    assign slen = (suffix_len_reg > SLEN_MAX) ? SLEN_MAX : suffix_len_reg;

    assign prefix_byte = prefix_chars_reg[prefix_count_reg[2:0]*psa_pkg::SYM_W +: psa_pkg::SYM_W];
    assign after_inc   = (after_count_reg >= slen) ? slen : after_count_reg + 4'd1;

    // window entry 0 is the newest symbol; suffix byte i lines up with entry slen-1-i
    always_comb
    begin
        logic [psa_pkg::LEN_W-1:0] widx;
        suffix_hit = 1'b1;
        for (int i = 0; i < SUFFIX_MAX; i++)
        begin
            widx = slen - 4'd1 - psa_pkg::LEN_W'(i);
            if ((psa_pkg::LEN_W'(i) < slen) &&
                (win_reg[widx[WIN_IDX_W-1:0]] !=
                 suffix_chars_reg[i*psa_pkg::SYM_W +: psa_pkg::SYM_W]))
            begin
                suffix_hit = 1'b0;
            end
        end
    end

    assign end_ok = (err_reg == psa_pkg::ERR_NONE) && (prefix_count_reg >= plen) &&
                    (after_count_reg >= slen) && suffix_hit;

    always_comb
    begin
        prefix_count_next = prefix_count_reg;
        after_count_next  = after_count_reg;
        err_next          = err_reg;
        win_next          = win_reg;
        status            = psa_pkg::ST_CONSUMED;
        if (in_item.kind == psa_pkg::KIND_END)
        begin
            status            = end_ok ? psa_pkg::ST_ACCEPTED : psa_pkg::ST_REJECTED;
            prefix_count_next = '0;
            after_count_next  = '0;
            err_next          = psa_pkg::ERR_NONE;
        end
        else if (err_reg != psa_pkg::ERR_NONE)
        begin
            status = psa_pkg::ST_IGNORED;
        end
        else if (!in_item.in_alpha)
        begin
            err_next = psa_pkg::ERR_ALPHABET;
            status   = psa_pkg::ST_NOT_IN_ALPHA;
        end
        else if (prefix_count_reg < plen)
        begin
            if (in_item.symbol == prefix_byte)
            begin
                prefix_count_next = prefix_count_reg + 4'd1;
            end
            else
            begin
                err_next = psa_pkg::ERR_PREFIX;
                status   = psa_pkg::ST_PREFIX_MISMATCH;
            end
        end
        else
        begin
            for (int k = 1; k < SUFFIX_MAX; k++)
            begin
                win_next[k] = win_reg[k-1];
            end
            win_next[0]      = in_item.symbol;
            after_count_next = after_inc;
        end
    end

    assign fire     = in_valid && !out_full;
    assign in_pop   = fire;
    assign out_push = fire;

    // an end beat reports the counts it found, not the cleared ones
    always_comb
    begin
        out_item.status = status;
        if (in_item.kind == psa_pkg::KIND_END)
        begin
            out_item.prefix_progress = prefix_count_reg;
            out_item.suffix_progress = after_count_reg;
        end
        else
        begin
            out_item.prefix_progress = prefix_count_next;
            out_item.suffix_progress = after_count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_count_reg <= '0;
            after_count_reg  <= '0;
            err_reg          <= psa_pkg::ERR_NONE;
        end
        else if (fire)
        begin
            prefix_count_reg <= prefix_count_next;
            after_count_reg  <= after_count_next;
            err_reg          <= err_next;
        end
    end

    // only entries written since the last end beat are ever compared
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// ===== hdl/prefix_suffix_string_acceptor_top.sv =====
// path: input beat -> mid queue register -> back end -> result queue register
// throughput: one beat per cycle sustained; each side stalls on its own two-entry queue
// per-beat work: alphabet lookup (front); prefix step, window shift, suffix compare (back)
// reset: rst_n asynchronous active low; clears config, counts, error state and queues
// the block takes beats as soon as rst_n is released
module prefix_suffix_string_acceptor_top #(
    parameter int PREFIX_MAX = psa_pkg::PREFIX_MAX_DEF,
    parameter int SUFFIX_MAX = psa_pkg::SUFFIX_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [psa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psa_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic                              kind,
    input  logic [psa_pkg::SYM_W-1:0]         symbol,
    output logic                              empty,
    input  logic                              pop,
    output logic [2:0]                        status,
    output logic [psa_pkg::LEN_W-1:0]         prefix_progress,
    output logic [psa_pkg::LEN_W-1:0]         suffix_progress
);

    localparam int MID_W = $bits(psa_pkg::mid_item_t);
    localparam int OUT_W = $bits(psa_pkg::out_item_t);

    logic               mid_push;
    logic               mid_full;
    logic               mid_pop;
    logic               mid_empty;
    psa_pkg::mid_item_t mid_wr;
    logic [MID_W-1:0]   mid_rd;
    logic               res_push;
    logic               res_full;
    psa_pkg::out_item_t res_wr;
    logic [OUT_W-1:0]   res_rd;
    psa_pkg::out_item_t res_head;

    psa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .kind      (kind),
        .symbol    (symbol),
        .q_full    (mid_full),
        .q_push    (mid_push),
        .q_item    (mid_wr)
    );

    psa_queue #(
        .WIDTH (MID_W)
    ) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (mid_push),
        .wr_data (MID_W'(mid_wr)),
        .full    (mid_full),
        .pop     (mid_pop),
        .rd_data (mid_rd),
        .empty   (mid_empty)
    );

    psa_back #(
        .PREFIX_MAX (PREFIX_MAX),
        .SUFFIX_MAX (SUFFIX_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (!mid_empty),
        .in_item   (psa_pkg::mid_item_t'(mid_rd)),
        .in_pop    (mid_pop),
        .out_full  (res_full),
        .out_push  (res_push),
        .out_item  (res_wr)
    );

    psa_queue #(
        .WIDTH (OUT_W)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (OUT_W'(res_wr)),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign full            = mid_full;
    assign res_head        = psa_pkg::out_item_t'(res_rd);
    assign status          = 3'(res_head.status);
    assign prefix_progress = res_head.prefix_progress;
    assign suffix_progress = res_head.suffix_progress;

endmodule

// ===== hdl/psa_checker.sv =====
`include "prefix_suffix_string_acceptor_top_assert.svh"

module psa_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      push,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [2:0]                status,
    input logic [psa_pkg::LEN_W-1:0] prefix_progress,
    input logic [psa_pkg::LEN_W-1:0] suffix_progress
);

    `PSA_ASSERT_NOW(a_status_code, !empty, status <= 3'(psa_pkg::ST_REJECTED), "bad status code")

    `PSA_ASSERT_NOW(a_progress_bound, !empty, (prefix_progress <= psa_pkg::LEN_LIMIT) && (suffix_progress <= psa_pkg::LEN_LIMIT), "progress beyond limit")

    `PSA_ASSERT_NEXT(a_head_holds, !empty && !pop, !empty && $stable(status) && $stable(prefix_progress) && $stable(suffix_progress), "result head changed while waiting")

    // a result showing up must follow an input beat accepted earlier
    `PSA_ASSERT_NOW(a_result_latency, $fell(empty), $past(push && !full, 2), "result without input beat")

endmodule

bind prefix_suffix_string_acceptor_top psa_checker u_psa_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .status          (status),
    .prefix_progress (prefix_progress),
    .suffix_progress (suffix_progress)
);

// ===== verif/tb_prefix_suffix_string_acceptor_top.sv =====
module tb_prefix_suffix_string_acceptor_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [psa_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [psa_pkg::CFG_W-1:0]     cfg_data;
    logic                          push;
    logic                          full;
    logic                          kind;
    logic [psa_pkg::SYM_W-1:0]     symbol;
    logic                          empty;
    logic                          pop;
    logic [2:0]                    status;
    logic [psa_pkg::LEN_W-1:0]     prefix_progress;
    logic [psa_pkg::LEN_W-1:0]     suffix_progress;

    // register shadow
    logic [63:0]               prefix_word;
    logic [63:0]               suffix_word;
    logic [psa_pkg::LEN_W-1:0] prefix_len_reg;
    logic [psa_pkg::LEN_W-1:0] suffix_len_reg;
    logic [63:0]               alpha_bank [psa_pkg::ALPHA_BANKS];

    // string state of the predictor
    int                        matched_prefix;
    int                        tail_count;
    logic [psa_pkg::SYM_W-1:0] tail_window [psa_pkg::SUFFIX_MAX_DEF];
    psa_pkg::err_t             latched_err;

    psa_pkg::out_item_t verdict_q [$];

    int fail_count;
    int directed_beats;
    int random_beats;
    int accepted_strings;
    int rejected_strings;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit random_mode;

    prefix_suffix_string_acceptor_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .symbol          (symbol),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .prefix_progress (prefix_progress),
        .suffix_progress (suffix_progress)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // advances the string state by one beat and returns the verdict it produces
    function automatic psa_pkg::out_item_t acceptor_step(logic k,
                                                         logic [psa_pkg::SYM_W-1:0] s);
        int                 plen;
        int                 slen;
        bit                 ok;
        psa_pkg::out_item_t r;
        plen = (prefix_len_reg > psa_pkg::PREFIX_MAX_DEF) ? psa_pkg::PREFIX_MAX_DEF
                                                          : prefix_len_reg;
        slen = (suffix_len_reg > psa_pkg::SUFFIX_MAX_DEF) ? psa_pkg::SUFFIX_MAX_DEF
                                                          : suffix_len_reg;
        if (k == psa_pkg::KIND_END)
        begin
            ok = (latched_err == psa_pkg::ERR_NONE) && (matched_prefix >= plen) &&
                 (tail_count >= slen);
            for (int i = 0; i < slen; i++)
            begin
                if (tail_window[slen - 1 - i] != suffix_word[8*i +: 8])
                    ok = 1'b0;
            end
            r.status          = ok ? psa_pkg::ST_ACCEPTED : psa_pkg::ST_REJECTED;
            r.prefix_progress = matched_prefix[psa_pkg::LEN_W-1:0];
            r.suffix_progress = tail_count[psa_pkg::LEN_W-1:0];
            matched_prefix = 0;
            tail_count     = 0;
            foreach (tail_window[j])
                tail_window[j] = '0;
            latched_err = psa_pkg::ERR_NONE;
            return r;
        end
        if (latched_err != psa_pkg::ERR_NONE)
        begin
            r.status = psa_pkg::ST_IGNORED;
        end
        else if (!alpha_bank[s[7:6]][s[5:0]])
        begin
            latched_err = psa_pkg::ERR_ALPHABET;
            r.status    = psa_pkg::ST_NOT_IN_ALPHA;
        end
        else if (matched_prefix < plen)
        begin
            if (s == prefix_word[8*matched_prefix +: 8])
            begin
                matched_prefix++;
                r.status = psa_pkg::ST_CONSUMED;
            end
            else
            begin
                latched_err = psa_pkg::ERR_PREFIX;
                r.status    = psa_pkg::ST_PREFIX_MISMATCH;
            end
        end
        else
        begin
            for (int j = psa_pkg::SUFFIX_MAX_DEF - 1; j > 0; j--)
                tail_window[j] = tail_window[j - 1];
            tail_window[0] = s;
            tail_count = (tail_count + 1 > slen) ? slen : tail_count + 1;
            r.status = psa_pkg::ST_CONSUMED;
        end
        r.prefix_progress = matched_prefix[psa_pkg::LEN_W-1:0];
        r.suffix_progress = tail_count[psa_pkg::LEN_W-1:0];
        return r;
    endfunction

    task automatic write_reg(psa_pkg::cfg_idx_t idx, logic [psa_pkg::CFG_W-1:0] v);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            psa_pkg::CFG_PREFIX_CHARS: prefix_word    = v;
            psa_pkg::CFG_PREFIX_LEN:   prefix_len_reg = v[psa_pkg::LEN_W-1:0];
            psa_pkg::CFG_SUFFIX_CHARS: suffix_word    = v;
            psa_pkg::CFG_SUFFIX_LEN:   suffix_len_reg = v[psa_pkg::LEN_W-1:0];
            psa_pkg::CFG_ALPHA_0:      alpha_bank[0]  = v;
            psa_pkg::CFG_ALPHA_1:      alpha_bank[1]  = v;
            psa_pkg::CFG_ALPHA_2:      alpha_bank[2]  = v;
            psa_pkg::CFG_ALPHA_3:      alpha_bank[3]  = v;
            default: ;
        endcase
    endtask

    task automatic send_beat(logic k, logic [psa_pkg::SYM_W-1:0] s);
        psa_pkg::out_item_t r;
        while ($urandom_range(99) < snd_idle_pct)
        begin
            @(negedge clk);
            push = 1'b0;
        end
        @(negedge clk);
        push   = 1'b1;
        kind   = k;
        symbol = s;
        @(posedge clk);
        while (full)
            @(posedge clk);
        r = acceptor_step(k, s);
        verdict_q.insert(verdict_q.size(), r);
        if (random_mode)
            random_beats++;
        else
            directed_beats++;
    endtask

    // lets every expected verdict come out so the block is idle
    task automatic drain();
        @(negedge clk);
        push = 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_accepting_string();
        write_reg(psa_pkg::CFG_PREFIX_CHARS, 64'h6261);
        write_reg(psa_pkg::CFG_PREFIX_LEN, 64'd2);
        write_reg(psa_pkg::CFG_SUFFIX_CHARS, 64'h7A2D);
        write_reg(psa_pkg::CFG_SUFFIX_LEN, 64'd2);
        // '-' and byte zero, then lower-case letters
        write_reg(psa_pkg::CFG_ALPHA_0, 64'h0000_2000_0000_0001);
        write_reg(psa_pkg::CFG_ALPHA_1, 64'h07FF_FFFE_0000_0000);
        write_reg(psa_pkg::CFG_ALPHA_2, 64'h0);
        write_reg(psa_pkg::CFG_ALPHA_3, 64'h0);
        send_beat(psa_pkg::KIND_SYMBOL, "a");
        send_beat(psa_pkg::KIND_SYMBOL, "b");
        send_beat(psa_pkg::KIND_SYMBOL, "c");
        send_beat(psa_pkg::KIND_SYMBOL, "-");
        send_beat(psa_pkg::KIND_SYMBOL, "z");
        send_beat(psa_pkg::KIND_END, 8'hFF);
    endtask

    task automatic test_error_latching();
        // 0xff fails both checks, alphabet must win
        send_beat(psa_pkg::KIND_SYMBOL, 8'hFF);
        send_beat(psa_pkg::KIND_SYMBOL, "x");
        send_beat(psa_pkg::KIND_END, 8'h00);
        send_beat(psa_pkg::KIND_SYMBOL, "x");
        send_beat(psa_pkg::KIND_SYMBOL, 8'h00);
        send_beat(psa_pkg::KIND_END, 8'h00);
        // prefix still incomplete at the end
        send_beat(psa_pkg::KIND_SYMBOL, "a");
        send_beat(psa_pkg::KIND_END, 8'h5A);
    endtask

    task automatic test_empty_and_overlong_lengths();
        drain();
        write_reg(psa_pkg::CFG_PREFIX_LEN, 64'd0);
        write_reg(psa_pkg::CFG_SUFFIX_LEN, 64'd0);
        send_beat(psa_pkg::KIND_SYMBOL, "q");
        send_beat(psa_pkg::KIND_END, 8'h00);
        drain();
        write_reg(psa_pkg::CFG_PREFIX_CHARS, {8{8'h61}});
        // all ones clips to the maximum prefix length
        write_reg(psa_pkg::CFG_PREFIX_LEN, '1);
        repeat (psa_pkg::PREFIX_MAX_DEF) send_beat(psa_pkg::KIND_SYMBOL, "a");
        send_beat(psa_pkg::KIND_END, 8'hA5);
    endtask

    task automatic test_reconfig_midstring();
        drain();
        write_reg(psa_pkg::CFG_PREFIX_LEN, 64'd0);
        write_reg(psa_pkg::CFG_SUFFIX_CHARS, 64'h7A7A7A);
        write_reg(psa_pkg::CFG_SUFFIX_LEN, 64'd3);
        repeat (3) send_beat(psa_pkg::KIND_SYMBOL, "z");
        drain();
        // stored count above the new length collapses on the next symbol
        write_reg(psa_pkg::CFG_SUFFIX_LEN, 64'd1);
        send_beat(psa_pkg::KIND_SYMBOL, "z");
        send_beat(psa_pkg::KIND_END, 8'h00);
    endtask

    task automatic run_random_phase(int n_items, int snd_pct, int rcv_pct);
        int                        start;
        int                        round_end;
        int                        plen;
        int                        slen;
        int                        ep;
        int                        es;
        int                        pick;
        int                        cut;
        logic [63:0]               pw;
        logic [63:0]               sw;
        logic [63:0]               lw;
        logic [63:0]               banks [psa_pkg::ALPHA_BANKS];
        logic [psa_pkg::SYM_W-1:0] c;
        logic [psa_pkg::SYM_W-1:0] members [$];
        logic [psa_pkg::SYM_W-1:0] str [$];
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        start = random_beats;
        while (random_beats - start < n_items)
        begin
            drain();
            plen = ($urandom_range(7) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
            slen = ($urandom_range(7) == 0) ? $urandom_range(15, 9) : $urandom_range(8);
            pw = {$urandom, $urandom};
            sw = {$urandom, $urandom};
            // a repeated suffix byte exercises overlapping restarts
            if ($urandom_range(3) == 0)
                sw = {8{pw[7:0]}};
            pick = $urandom_range(9);
            foreach (banks[b])
                banks[b] = {$urandom, $urandom};
            if (pick == 0)
            begin
                foreach (banks[b])
                    banks[b] = '1;
            end
            else if (pick == 1)
            begin
                foreach (banks[b])
                    banks[b] = '0;
            end
            else if (pick >= 4)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    c = pw[8*i +: 8];
                    banks[c[7:6]][c[5:0]] = 1'b1;
                    c = sw[8*i +: 8];
                    banks[c[7:6]][c[5:0]] = 1'b1;
                end
            end
            write_reg(psa_pkg::CFG_PREFIX_CHARS, pw);
            lw = {$urandom, $urandom};
            lw[3:0] = 4'(plen);
            write_reg(psa_pkg::CFG_PREFIX_LEN, lw);
            write_reg(psa_pkg::CFG_SUFFIX_CHARS, sw);
            lw = {$urandom, $urandom};
            lw[3:0] = 4'(slen);
            write_reg(psa_pkg::CFG_SUFFIX_LEN, lw);
            write_reg(psa_pkg::CFG_ALPHA_0, banks[0]);
            write_reg(psa_pkg::CFG_ALPHA_1, banks[1]);
            write_reg(psa_pkg::CFG_ALPHA_2, banks[2]);
            write_reg(psa_pkg::CFG_ALPHA_3, banks[3]);
            members.delete();
            for (int v = 0; v < 256; v++)
            begin
                if (alpha_bank[v >> 6][v & 63])
                    members.insert(members.size(), v[7:0]);
            end
            ep = (plen > psa_pkg::PREFIX_MAX_DEF) ? psa_pkg::PREFIX_MAX_DEF : plen;
            es = (slen > psa_pkg::SUFFIX_MAX_DEF) ? psa_pkg::SUFFIX_MAX_DEF : slen;
            round_end = random_beats + $urandom_range(40, 80);
            while (random_beats < round_end && random_beats - start < n_items)
            begin
                str.delete();
                pick = $urandom_range(99);
                if (pick < 80)
                begin
                    for (int i = 0; i < ep; i++)
                        str.insert(str.size(), pw[8*i +: 8]);
                    repeat ($urandom_range(4))
                    begin
                        if (members.size() != 0)
                            str.insert(str.size(),
                                       members[$urandom_range(members.size() - 1)]);
                        else
                            str.insert(str.size(), 8'($urandom_range(255)));
                    end
                    for (int i = 0; i < es; i++)
                        str.insert(str.size(), sw[8*i +: 8]);
                    // broken strings: one corrupted byte or a truncated tail
                    if (pick >= 62 && str.size() != 0)
                    begin
                        if ($urandom_range(1))
                        begin
                            str[$urandom_range(str.size() - 1)] = 8'($urandom_range(255));
                        end
                        else
                        begin
                            cut = $urandom_range(str.size() - 1);
                            while (str.size() > cut)
                                str.delete(str.size() - 1);
                        end
                    end
                end
                else
                begin
                    repeat ($urandom_range(6))
                    begin
                        if (members.size() != 0 && $urandom_range(1))
                            str.insert(str.size(),
                                       members[$urandom_range(members.size() - 1)]);
                        else
                            str.insert(str.size(), 8'($urandom_range(255)));
                    end
                end
                foreach (str[i])
                    send_beat(psa_pkg::KIND_SYMBOL, str[i]);
                // now and then a string runs on into the next one
                if ($urandom_range(19) != 0)
                    send_beat(psa_pkg::KIND_END, 8'($urandom_range(255)));
            end
        end
    endtask

    // result side
    initial
    begin
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            pop = ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    initial
    begin
        psa_pkg::out_item_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (want.status == psa_pkg::ST_ACCEPTED)
                        accepted_strings++;
                    if (want.status == psa_pkg::ST_REJECTED)
                        rejected_strings++;
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_count++;
                    end
                    if (prefix_progress !== want.prefix_progress)
                    begin
                        $error("prefix_progress: expected %0d, got %0d",
                               want.prefix_progress, prefix_progress);
                        fail_count++;
                    end
                    if (suffix_progress !== want.suffix_progress)
                    begin
                        $error("suffix_progress: expected %0d, got %0d",
                               want.suffix_progress, suffix_progress);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int stuck_cycles;
        stuck_cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no beat moved for %0d cycles, %0d verdicts outstanding",
                       stuck_cycles, verdict_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = psa_pkg::CFG_PREFIX_CHARS;
        cfg_data  = '0;
        push      = 1'b0;
        kind      = psa_pkg::KIND_SYMBOL;
        symbol    = '0;
        prefix_word    = '0;
        suffix_word    = '0;
        prefix_len_reg = '0;
        suffix_len_reg = '0;
        foreach (alpha_bank[b])
            alpha_bank[b] = '0;
        matched_prefix = 0;
        tail_count     = 0;
        foreach (tail_window[j])
            tail_window[j] = '0;
        latched_err      = psa_pkg::ERR_NONE;
        fail_count       = 0;
        directed_beats   = 0;
        random_beats     = 0;
        accepted_strings = 0;
        rejected_strings = 0;
        random_mode      = 1'b0;
        snd_idle_pct     = 17;
        rcv_idle_pct     = 45;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_accepting_string();
        test_error_latching();
        test_empty_and_overlong_lengths();
        test_reconfig_midstring();

        random_mode = 1'b1;
        run_random_phase(240, 17, 45);
        run_random_phase(230, 45, 17);
        run_random_phase(230, 0, 0);
        drain();

        $display("covered %0d directed and %0d random beats under three stall profiles",
                 directed_beats, random_beats);
        $display("strings seen: %0d accepted, %0d rejected", accepted_strings, rejected_strings);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
